/* rtl/glt_pkg.sv */
// ----------------------------------------------------------------------------
// glt_pkg
// Shared types, codes and fixed-point helpers for the glyph layout engine.
// ----------------------------------------------------------------------------
`default_nettype none

package glt_pkg;

  // Opcodes of an input item
  typedef enum logic [1:0] {
    OP_GLYPH = 2'd0,
    OP_BEGIN = 2'd1,
    OP_CHAR  = 2'd2
  } opcode_t;

  // Special character codes
  localparam logic [15:0] CHAR_SPACE   = 16'd32;
  localparam logic [15:0] CHAR_NEWLINE = 16'd10;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_LETTER_HEIGHT   = 3'd0;
  localparam logic [2:0] REG_LETTER_SPACING  = 3'd1;
  localparam logic [2:0] REG_LINE_SPACING    = 3'd2;
  localparam logic [2:0] REG_LINE_LENGTH     = 3'd3;
  localparam logic [2:0] REG_CHAR_CODE_START = 3'd4;
  localparam logic [2:0] REG_GLYPH_COUNT     = 3'd5;
  localparam logic [2:0] REG_GLYPH_SCALE     = 3'd6;

  // Q3.14 position range
  localparam logic signed [27:0] POS_MAX = 28'sd131071;
  localparam logic signed [27:0] POS_MIN = -28'sd131072;
  localparam logic [22:0]        SCALE_MAX = 23'd131071;

  // Configuration registers
  typedef struct packed {
    logic [14:0] letter_height;
    logic [14:0] letter_spacing;
    logic [14:0] line_spacing;
    logic [7:0]  line_length;
    logic [15:0] char_code_start;
    logic [8:0]  glyph_count;
    logic [15:0] glyph_scale;
  } cfg_t;

  // One glyph table entry
  typedef struct packed {
    logic [15:0] tex_x;
    logic [15:0] tex_y;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] drop;
  } glyph_entry_t;

  // Clamp a wide signed value into the signed Q3.14 range
  function automatic logic signed [17:0] sat_pos(input logic signed [27:0] v);
    logic signed [17:0] r;
    if (v > POS_MAX) begin
      r = 18'sh1FFFF;
    end else if (v < POS_MIN) begin
      r = 18'sh20000;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  // size * scale is Q0.16 * Q8.8; round to Q3.14 and clamp
  function automatic logic [16:0] scale_round(input logic [31:0] prod);
    logic [32:0] sum;
    logic [22:0] q;
    sum = {1'b0, prod} + 33'd512;
    q   = sum[32:10];
    return (q > SCALE_MAX) ? 17'h1FFFF : q[16:0];
  endfunction

  // |drop| * height * scale, rounded half up to Q3.14
  function automatic logic [24:0] drop_round(input logic [47:0] mag);
    logic [47:0] sum;
    sum = mag + 48'h400000;
    return sum[47:23];
  endfunction

endpackage

`default_nettype wire

/* rtl/glt_table.sv */
// ----------------------------------------------------------------------------
// glt_table
// Glyph table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module glt_table
  import glt_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic         clk,
  input  wire logic         wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire glyph_entry_t wr_data,
  input  wire logic         rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output glyph_entry_t      rd_data
);

  glyph_entry_t mem [DEPTH];
  glyph_entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/glt_mul.sv */
// ----------------------------------------------------------------------------
// glt_mul
// Shared 16 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module glt_mul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] a,
  input  wire logic [31:0] b,
  output logic      [47:0] p
);

  logic [47:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= 48'(a) * 48'(b);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

/* rtl/glt_seq.sv */
// ----------------------------------------------------------------------------
// glt_seq
// Layout sequencer: cursor and line state, glyph lookup, three passes
// through the shared multiplier and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module glt_seq
  import glt_pkg::*;
#(
  parameter int GLYPHS       = 256,
  parameter int MAX_VERTICES = 256,
  parameter int AW           = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cfg_t                cfg,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [15:0]         in_char_code,
  input  wire logic [7:0]          in_glyph_slot,
  input  wire logic [15:0]         in_glyph_tex_x,
  input  wire logic [15:0]         in_glyph_tex_y,
  input  wire logic [15:0]         in_glyph_width,
  input  wire logic [15:0]         in_glyph_height,
  input  wire logic signed [15:0]  in_glyph_drop,
  // glyph table
  output logic                     tbl_wr_en,
  output logic [AW-1:0]            tbl_wr_addr,
  output glyph_entry_t             tbl_wr_data,
  output logic                     tbl_rd_en,
  output logic [AW-1:0]            tbl_rd_addr,
  input  wire glyph_entry_t        tbl_rd_data,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_vertex_index,
  output logic signed [17:0]       out_pos_x,
  output logic signed [17:0]       out_pos_y,
  output logic [16:0]              out_scale_x,
  output logic [16:0]              out_scale_y,
  output logic [15:0]              out_tex_x,
  output logic [15:0]              out_tex_y,
  output logic [15:0]              out_tex_w,
  output logic [15:0]              out_tex_h
);

  localparam int QB = $clog2(MAX_VERTICES + 1);
  localparam int QW = (QB > 8) ? QB : 8;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MW   = 5'b00010,
    S_MH   = 5'b00100,
    S_MD   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic signed [17:0] cx_r, cx_nxt;
  logic signed [17:0] cy_r, cy_nxt;
  logic [8:0]         lc_r, lc_nxt;
  logic [QW-1:0]      qc_r, qc_nxt;
  logic [16:0]        sx_r, sy_r;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         vidx_r;
  logic signed [17:0] opx_r, opy_r;
  logic [16:0]        osx_r, osy_r;
  logic [15:0]        otx_r, oty_r, otw_r, oth_r;

  logic               accept;
  logic [15:0]        idx16;
  logic [15:0]        slot16;
  logic               in_rng;
  logic               is_space, is_nl, wrap;
  logic signed [17:0] cx_sp;
  logic signed [17:0] cy_wrap;
  logic [8:0]         lc_w;
  logic               glyph_hit;
  logic               slot_ok;

  logic               mul_en;
  logic [15:0]        mul_a;
  logic [31:0]        mul_b;
  logic [47:0]        mul_p;
  logic [15:0]        drop_mag;
  logic [24:0]        drop_r;
  logic signed [27:0] drop_term;
  logic signed [17:0] py;
  logic signed [17:0] cx_adv;
  logic               emit;
  logic               out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Character classification and cursor updates for the accept cycle
  assign idx16    = in_char_code - cfg.char_code_start;
  assign in_rng   = (in_char_code >= cfg.char_code_start)
                 && (idx16 < 16'(cfg.glyph_count))
                 && ({1'b0, idx16} < 17'(GLYPHS));
  assign is_space = (in_char_code == CHAR_SPACE);
  assign is_nl    = (in_char_code == CHAR_NEWLINE);
  assign wrap     = (lc_r > {1'b0, cfg.line_length}) || is_nl;
  assign cx_sp    = is_space ? sat_pos(28'(cx_r) + 28'(cfg.letter_height)
                                       + 28'(cfg.letter_spacing)) : cx_r;
  assign cy_wrap  = sat_pos(28'(cy_r) - 28'(cfg.letter_height) - 28'(cfg.line_spacing));
  assign lc_w     = wrap ? 9'd0 : lc_r;
  assign glyph_hit = in_rng && !is_space && !is_nl;

  // Glyph table ports
  assign slot16      = 16'(in_glyph_slot);
  assign slot_ok     = (13'(in_glyph_slot) < 13'(GLYPHS));
  assign tbl_wr_en   = accept && (in_opcode == OP_GLYPH) && slot_ok;
  assign tbl_wr_addr = slot16[AW-1:0];
  assign tbl_wr_data = '{tex_x: in_glyph_tex_x, tex_y: in_glyph_tex_y,
                         width: in_glyph_width, height: in_glyph_height,
                         drop: in_glyph_drop};
  assign tbl_rd_en   = accept && (in_opcode == OP_CHAR) && glyph_hit;
  assign tbl_rd_addr = idx16[AW-1:0];

  // Shared multiplier operand select: width, height, then drop
  assign drop_mag = tbl_rd_data.drop[15] ? 16'(-tbl_rd_data.drop) : tbl_rd_data.drop;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = tbl_rd_data.width;
    mul_b  = 32'(cfg.glyph_scale);
    case (state_r)
      S_MW: begin
        mul_en = 1'b1;
      end
      S_MH: begin
        mul_en = 1'b1;
        mul_a  = tbl_rd_data.height;
      end
      S_MD: begin
        mul_en = 1'b1;
        mul_a  = drop_mag;
        mul_b  = mul_p[31:0];
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  glt_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Finish: drop term, final y, cursor advance
  assign drop_r    = drop_round(mul_p);
  assign drop_term = tbl_rd_data.drop[15] ? -28'(drop_r) : 28'(drop_r);
  assign py        = sat_pos(28'(cy_r) - drop_term);
  assign cx_adv    = sat_pos(28'(cx_r) + 28'(sx_r) + 28'(cfg.letter_spacing));
  assign emit      = (qc_r < QW'(MAX_VERTICES));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    lc_nxt        = lc_r;
    qc_nxt        = qc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_opcode == OP_BEGIN)) begin
          cx_nxt = '0;
          cy_nxt = '0;
          lc_nxt = '0;
          qc_nxt = '0;
        end else if (accept && (in_opcode == OP_CHAR)) begin
          cx_nxt = wrap ? 18'sd0 : cx_sp;
          cy_nxt = wrap ? cy_wrap : cy_r;
          lc_nxt = in_rng ? lc_w + 9'd1 : lc_w;
          if (glyph_hit) begin
            state_nxt = S_MW;
          end
        end
      end
      S_MW: begin
        state_nxt = S_MH;
      end
      S_MH: begin
        state_nxt = S_MD;
      end
      S_MD: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!emit || out_free) begin
          cx_nxt    = cx_adv;
          state_nxt = S_IDLE;
          if (emit) begin
            qc_nxt        = qc_r + QW'(1);
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cx_r        <= '0;
      cy_r        <= '0;
      lc_r        <= '0;
      qc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      lc_r        <= lc_nxt;
      qc_r        <= qc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scales from the first two multiplier passes
  always_ff @(posedge clk) begin
    if (state_r == S_MH) begin
      sx_r <= scale_round(mul_p[31:0]);
    end
    if (state_r == S_MD) begin
      sy_r <= scale_round(mul_p[31:0]);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && emit && out_free) begin
      vidx_r <= qc_r[7:0];
      opx_r  <= cx_r;
      opy_r  <= py;
      osx_r  <= sx_r;
      osy_r  <= sy_r;
      otx_r  <= tbl_rd_data.tex_x;
      oty_r  <= tbl_rd_data.tex_y;
      otw_r  <= tbl_rd_data.width;
      oth_r  <= tbl_rd_data.height;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = vidx_r;
  assign out_pos_x        = opx_r;
  assign out_pos_y        = opy_r;
  assign out_scale_x      = osx_r;
  assign out_scale_y      = osy_r;
  assign out_tex_x        = otx_r;
  assign out_tex_y        = oty_r;
  assign out_tex_w        = otw_r;
  assign out_tex_h        = oth_r;

endmodule

`default_nettype wire

/* rtl/glyph_layout_engine_unit.sv */
// ----------------------------------------------------------------------------
// glyph_layout_engine_unit
// Text layout engine: glyph table writes, string start and per-character
// quad generation with line wrap and saturating Q3.14 arithmetic.
// ----------------------------------------------------------------------------
//  Channel  | Ports                         | Handshake
//  ---------+-------------------------------+----------------------------
//  input    | in_opcode .. in_glyph_drop    | in_valid / in_ready
//  result   | out_vertex_index .. out_tex_h | out_valid / out_ready
//  config   | psel penable pwrite paddr ... | APB write, pready tied high
//
//  Table writes, string starts, spaces, newlines and codes outside the
//  glyph range leave the input ready. A glyph holds the input busy for a
//  table read, then three passes through the shared 16x32 multiplier
//  (width, height, drop) and a finish step.
//  The finish step waits while an earlier result is still held.
//  Reset (rst_n low, synchronous) clears cursor and counts and loads the
//  register defaults; the glyph table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_layout_engine_unit
  import glt_pkg::*;
#(
  parameter int GLYPHS       = 256,
  parameter int MAX_VERTICES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [15:0]        in_char_code,
  input  wire logic [7:0]         in_glyph_slot,
  input  wire logic [15:0]        in_glyph_tex_x,
  input  wire logic [15:0]        in_glyph_tex_y,
  input  wire logic [15:0]        in_glyph_width,
  input  wire logic [15:0]        in_glyph_height,
  input  wire logic signed [15:0] in_glyph_drop,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_vertex_index,
  output logic signed [17:0]      out_pos_x,
  output logic signed [17:0]      out_pos_y,
  output logic [16:0]             out_scale_x,
  output logic [16:0]             out_scale_y,
  output logic [15:0]             out_tex_x,
  output logic [15:0]             out_tex_y,
  output logic [15:0]             out_tex_w,
  output logic [15:0]             out_tex_h
);

  localparam int AW = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;

  cfg_t          cfg_r;
  logic          cfg_wr;
  logic [2:0]    reg_idx;
  logic          tbl_wr_en;
  logic [AW-1:0] tbl_wr_addr;
  glyph_entry_t  tbl_wr_data;
  logic          tbl_rd_en;
  logic [AW-1:0] tbl_rd_addr;
  glyph_entry_t  tbl_rd_data;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.letter_height   <= 15'd1638;
      cfg_r.letter_spacing  <= 15'd0;
      cfg_r.line_spacing    <= 15'd0;
      cfg_r.line_length     <= 8'd255;
      cfg_r.char_code_start <= 16'd32;
      cfg_r.glyph_count     <= 9'd0;
      cfg_r.glyph_scale     <= 16'd256;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LETTER_HEIGHT:   cfg_r.letter_height   <= pwdata[14:0];
        REG_LETTER_SPACING:  cfg_r.letter_spacing  <= pwdata[14:0];
        REG_LINE_SPACING:    cfg_r.line_spacing    <= pwdata[14:0];
        REG_LINE_LENGTH:     cfg_r.line_length     <= pwdata[7:0];
        REG_CHAR_CODE_START: cfg_r.char_code_start <= pwdata[15:0];
        REG_GLYPH_COUNT:     cfg_r.glyph_count     <= pwdata[8:0];
        REG_GLYPH_SCALE:     cfg_r.glyph_scale     <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_LETTER_HEIGHT:   prdata = 32'(cfg_r.letter_height);
      REG_LETTER_SPACING:  prdata = 32'(cfg_r.letter_spacing);
      REG_LINE_SPACING:    prdata = 32'(cfg_r.line_spacing);
      REG_LINE_LENGTH:     prdata = 32'(cfg_r.line_length);
      REG_CHAR_CODE_START: prdata = 32'(cfg_r.char_code_start);
      REG_GLYPH_COUNT:     prdata = 32'(cfg_r.glyph_count);
      REG_GLYPH_SCALE:     prdata = 32'(cfg_r.glyph_scale);
      default:             prdata = 32'd0;
    endcase
  end

  glt_table #(
    .DEPTH (GLYPHS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  glt_seq #(
    .GLYPHS       (GLYPHS),
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_char_code     (in_char_code),
    .in_glyph_slot    (in_glyph_slot),
    .in_glyph_tex_x   (in_glyph_tex_x),
    .in_glyph_tex_y   (in_glyph_tex_y),
    .in_glyph_width   (in_glyph_width),
    .in_glyph_height  (in_glyph_height),
    .in_glyph_drop    (in_glyph_drop),
    .tbl_wr_en        (tbl_wr_en),
    .tbl_wr_addr      (tbl_wr_addr),
    .tbl_wr_data      (tbl_wr_data),
    .tbl_rd_en        (tbl_rd_en),
    .tbl_rd_addr      (tbl_rd_addr),
    .tbl_rd_data      (tbl_rd_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_index (out_vertex_index),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_scale_x      (out_scale_x),
    .out_scale_y      (out_scale_y),
    .out_tex_x        (out_tex_x),
    .out_tex_y        (out_tex_y),
    .out_tex_w        (out_tex_w),
    .out_tex_h        (out_tex_h)
  );

endmodule

`default_nettype wire

/* rtl/glt_checker.sv */
// ----------------------------------------------------------------------------
// glt_checker
// Port-level checks for the glyph layout engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module glt_checker
  import glt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_vertex_index,
  input wire logic [17:0] out_pos_x,
  input wire logic [17:0] out_pos_y
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_index)
      && $stable(out_pos_x) && $stable(out_pos_y))
    else $error("result changed while stalled");

  // Anything but a character item leaves the input ready in the next cycle
  a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode != OP_CHAR) |=> in_ready)
    else $error("non-character item held the input");

  // A new result only comes out of a busy sequencer
  a_rose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a busy cycle");

  // No result directly on the edge after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result one cycle after accept");

endmodule

bind glyph_layout_engine_unit glt_checker u_glt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_opcode        (in_opcode),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_vertex_index (out_vertex_index),
  .out_pos_x        (out_pos_x),
  .out_pos_y        (out_pos_y)
);

`default_nettype wire

/* tb/glyph_layout_engine_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_layout_engine_unit_tb
// Self-checking bench for the glyph layout engine. A scoreboard class keeps
// its own copy of the cursor, the counters, the glyph table and the
// registers, and it works out the quad that each accepted item should emit.
// Directed items cover extremes, wrap, saturation and out-of-range codes.
// Random strings then run under several register settings, with random
// gaps on both channels and one long result stall.
// ----------------------------------------------------------------------------

module glyph_layout_engine_unit_tb;
  import glt_pkg::*;

  localparam int          TABLE_DEPTH   = 256;
  localparam int          VERTEX_LIMIT  = 256;
  localparam int          ITEM_TARGET   = 1100;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam logic [1:0]  OP_RESERVED   = 2'd3;
  localparam longint      NDC_MAX       = 131071;
  localparam longint      NDC_MIN       = -131072;
  localparam longint      SIZE_MAX      = 131071;

  // One input item
  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        char_code;
    logic [7:0]         glyph_slot;
    logic [15:0]        tex_x;
    logic [15:0]        tex_y;
    logic [15:0]        width;
    logic [15:0]        height;
    logic signed [15:0] drop;
  } text_item_t;

  // One emitted quad
  typedef struct packed {
    logic [7:0]         vertex_index;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic [16:0]        scale_x;
    logic [16:0]        scale_y;
    logic [15:0]        tex_x;
    logic [15:0]        tex_y;
    logic [15:0]        tex_w;
    logic [15:0]        tex_h;
  } quad_t;

  // --------------------------------------------------------------------------
  // Layout predictor and quad checker
  // --------------------------------------------------------------------------
  class quad_scoreboard;
    int unsigned letter_h, letter_gap, line_gap, line_len;
    int unsigned code_base, glyph_total, atlas_scale;
    longint      cur_x, cur_y;
    int unsigned line_cnt, quad_cnt;
    logic [31:0] origin_tab [TABLE_DEPTH];
    logic [31:0] extent_tab [TABLE_DEPTH];
    logic [15:0] drop_tab [TABLE_DEPTH];
    quad_t       expected_quads [$];
    int unsigned errors;

    function new();
      letter_h    = 1638;
      letter_gap  = 0;
      line_gap    = 0;
      line_len    = 255;
      code_base   = 32;
      glyph_total = 0;
      atlas_scale = 256;
      cur_x       = 0;
      cur_y       = 0;
      line_cnt    = 0;
      quad_cnt    = 0;
      errors      = 0;
    endfunction

    function void write_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_LETTER_HEIGHT:   letter_h    = value & 32'h7FFF;
        REG_LETTER_SPACING:  letter_gap  = value & 32'h7FFF;
        REG_LINE_SPACING:    line_gap    = value & 32'h7FFF;
        REG_LINE_LENGTH:     line_len    = value & 32'hFF;
        REG_CHAR_CODE_START: code_base   = value & 32'hFFFF;
        REG_GLYPH_COUNT:     glyph_total = value & 32'h1FF;
        REG_GLYPH_SCALE:     atlas_scale = value & 32'hFFFF;
        default: ;
      endcase
    endfunction

    function longint clamp_ndc(longint v);
      if (v > NDC_MAX) return NDC_MAX;
      if (v < NDC_MIN) return NDC_MIN;
      return v;
    endfunction

    // Q0.16 atlas size times Q8.8 scale, rounded to Q3.14
    function longint atlas_to_ndc(longint size);
      longint p;
      p = (size * longint'(atlas_scale) + 512) >>> 10;
      return (p > SIZE_MAX) ? SIZE_MAX : p;
    endfunction

    // Vertical drop, rounded half away from zero
    function longint drop_shift(logic [15:0] bits, longint h);
      longint d, mag, r;
      d   = longint'($signed(bits));
      mag = ((d < 0) ? -d : d) * h * longint'(atlas_scale);
      r   = (mag + (longint'(1) << 22)) >>> 23;
      return (d < 0) ? -r : r;
    endfunction

    function void lay_out_char(logic [15:0] code);
      int unsigned lim, idx;
      longint      w, h, sx, sy, py;
      quad_t       q;
      if (code == CHAR_SPACE)
        cur_x = clamp_ndc(cur_x + longint'(letter_h) + longint'(letter_gap));
      // wrap comes before the range check
      if (line_cnt > line_len || code == CHAR_NEWLINE) begin
        cur_x    = 0;
        cur_y    = clamp_ndc(cur_y - longint'(letter_h) - longint'(line_gap));
        line_cnt = 0;
      end
      lim = (glyph_total < TABLE_DEPTH) ? glyph_total : TABLE_DEPTH;
      if (code < code_base) return;
      idx = code - code_base;
      if (idx >= lim) return;
      line_cnt = (line_cnt + 1) & 9'h1FF;
      if (code == CHAR_SPACE || code == CHAR_NEWLINE) return;
      w  = longint'(extent_tab[idx][15:0]);
      h  = longint'(extent_tab[idx][31:16]);
      sx = atlas_to_ndc(w);
      sy = atlas_to_ndc(h);
      py = clamp_ndc(cur_y - drop_shift(drop_tab[idx], h));
      // buffer full: cursor still moves, nothing emitted
      if (quad_cnt < VERTEX_LIMIT) begin
        q.vertex_index = quad_cnt[7:0];
        q.pos_x        = cur_x[17:0];
        q.pos_y        = py[17:0];
        q.scale_x      = sx[16:0];
        q.scale_y      = sy[16:0];
        q.tex_x        = origin_tab[idx][15:0];
        q.tex_y        = origin_tab[idx][31:16];
        q.tex_w        = w[15:0];
        q.tex_h        = h[15:0];
        expected_quads.push_back(q);
        quad_cnt++;
      end
      cur_x = clamp_ndc(cur_x + sx + longint'(letter_gap));
    endfunction

    function void take_item(text_item_t it);
      case (it.opcode)
        OP_GLYPH: begin
          origin_tab[it.glyph_slot] = {it.tex_y, it.tex_x};
          extent_tab[it.glyph_slot] = {it.height, it.width};
          drop_tab[it.glyph_slot]   = it.drop;
        end
        OP_BEGIN: begin
          cur_x    = 0;
          cur_y    = 0;
          line_cnt = 0;
          quad_cnt = 0;
        end
        OP_CHAR: lay_out_char(it.char_code);
        default: ;
      endcase
    endfunction

    function string quad_text(quad_t q);
      return $sformatf("idx=%0d x=%0d y=%0d sx=%0d sy=%0d tex=%h/%h/%h/%h",
                       q.vertex_index, q.pos_x, q.pos_y, q.scale_x, q.scale_y,
                       q.tex_x, q.tex_y, q.tex_w, q.tex_h);
    endfunction

    function void check_quad(quad_t got);
      quad_t want;
      string bad;
      if (expected_quads.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected quad: %s", $realtime, quad_text(got));
        return;
      end
      want = expected_quads.pop_front();
      bad  = "";
      if (got.vertex_index !== want.vertex_index) bad = {bad, " vertex_index"};
      if (got.pos_x !== want.pos_x)               bad = {bad, " pos_x"};
      if (got.pos_y !== want.pos_y)               bad = {bad, " pos_y"};
      if (got.scale_x !== want.scale_x)           bad = {bad, " scale_x"};
      if (got.scale_y !== want.scale_y)           bad = {bad, " scale_y"};
      if (got.tex_x !== want.tex_x)               bad = {bad, " tex_x"};
      if (got.tex_y !== want.tex_y)               bad = {bad, " tex_y"};
      if (got.tex_w !== want.tex_w)               bad = {bad, " tex_w"};
      if (got.tex_h !== want.tex_h)               bad = {bad, " tex_h"};
      if (bad != "") begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] quad mismatch in%s", $realtime, bad);
          $display("  expected %s", quad_text(want));
          $display("  actual   %s", quad_text(got));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and instance
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode = '0;
  logic [15:0]        in_char_code = '0;
  logic [7:0]         in_glyph_slot = '0;
  logic [15:0]        in_glyph_tex_x = '0;
  logic [15:0]        in_glyph_tex_y = '0;
  logic [15:0]        in_glyph_width = '0;
  logic [15:0]        in_glyph_height = '0;
  logic signed [15:0] in_glyph_drop = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_vertex_index;
  logic signed [17:0] out_pos_x;
  logic signed [17:0] out_pos_y;
  logic [16:0]        out_scale_x;
  logic [16:0]        out_scale_y;
  logic [15:0]        out_tex_x;
  logic [15:0]        out_tex_y;
  logic [15:0]        out_tex_w;
  logic [15:0]        out_tex_h;

  quad_scoreboard sb = new();
  bit             loaded [TABLE_DEPTH];
  int unsigned    items_sent = 0;
  bit             steady_input = 1'b0;
  bit             hold_req = 1'b0;
  int unsigned    cycle_count = 0;

  glyph_layout_engine_unit #(
    .GLYPHS       (TABLE_DEPTH),
    .MAX_VERTICES (VERTEX_LIMIT)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_char_code     (in_char_code),
    .in_glyph_slot    (in_glyph_slot),
    .in_glyph_tex_x   (in_glyph_tex_x),
    .in_glyph_tex_y   (in_glyph_tex_y),
    .in_glyph_width   (in_glyph_width),
    .in_glyph_height  (in_glyph_height),
    .in_glyph_drop    (in_glyph_drop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_index (out_vertex_index),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_scale_x      (out_scale_x),
    .out_scale_y      (out_scale_y),
    .out_tex_x        (out_tex_x),
    .out_tex_y        (out_tex_y),
    .out_tex_w        (out_tex_w),
    .out_tex_h        (out_tex_h)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("glyph_layout_engine_unit_tb: FAIL");
      $finish;
    end
  end

  // Quad monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_quad('{out_vertex_index, out_pos_x, out_pos_y, out_scale_x,
                      out_scale_y, out_tex_x, out_tex_y, out_tex_w, out_tex_h});
  end

  // Result-side ready: random runs and stalls, plus one long hold-off
  initial begin
    int unsigned run_left;
    int unsigned r;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready <= 1'b1;
          r = $urandom_range(0, 99);
          run_left = (r < 70) ? $urandom_range(0, 11) :
                     (r < 92) ? $urandom_range(12, 60) : $urandom_range(100, 300);
        end else begin
          out_ready <= 1'b0;
          r = $urandom_range(0, 99);
          run_left = (r < 60) ? $urandom_range(0, 2) :
                     (r < 92) ? $urandom_range(3, 9) : $urandom_range(20, 80);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (steady_input) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic text_item_t noise_item(logic [1:0] op);
    text_item_t it;
    it.opcode     = op;
    it.char_code  = 16'($urandom);
    it.glyph_slot = 8'($urandom);
    it.tex_x      = 16'($urandom);
    it.tex_y      = 16'($urandom);
    it.width      = 16'($urandom);
    it.height     = 16'($urandom);
    it.drop       = 16'($urandom);
    return it;
  endfunction

  function automatic text_item_t char_item(logic [15:0] code);
    text_item_t it;
    it           = noise_item(OP_CHAR);
    it.char_code = code;
    return it;
  endfunction

  function automatic text_item_t glyph_item(logic [7:0] slot, logic [15:0] tx,
                                            logic [15:0] ty, logic [15:0] w,
                                            logic [15:0] h, logic [15:0] d);
    return '{OP_GLYPH, 16'($urandom), slot, tx, ty, w, h, d};
  endfunction

  function automatic int unsigned glyph_limit();
    return (sb.glyph_total < TABLE_DEPTH) ? sb.glyph_total : TABLE_DEPTH;
  endfunction

  // A code may be sent unless it would read a table entry never written
  function automatic bit code_allowed(logic [15:0] code);
    if (code == CHAR_SPACE || code == CHAR_NEWLINE) return 1'b1;
    if (code < sb.code_base) return 1'b1;
    if (code - sb.code_base >= glyph_limit()) return 1'b1;
    return loaded[code - sb.code_base];
  endfunction

  function automatic logic [15:0] pick_glyph_code();
    int unsigned idx, code;
    if (glyph_limit() == 0) return CHAR_SPACE;
    repeat (8) begin
      idx  = $urandom_range(0, glyph_limit() - 1);
      code = sb.code_base + idx;
      if (code <= 32'hFFFF && loaded[idx] && code_allowed(code[15:0]))
        return code[15:0];
    end
    return CHAR_SPACE;
  endfunction

  function automatic logic [15:0] pick_code();
    int unsigned r;
    logic [15:0] c;
    r = $urandom_range(0, 99);
    if (r < 10) return CHAR_SPACE;
    if (r < 18) return CHAR_NEWLINE;
    if (r < 28) begin
      c = 16'($urandom);
      return code_allowed(c) ? c : CHAR_SPACE;
    end
    return pick_glyph_code();
  endfunction

  function automatic int unsigned pick_range(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_item(input text_item_t it);
    int unsigned gap;
    gap = sender_gap();
    @(negedge clk);
    in_valid        <= 1'b1;
    in_opcode       <= it.opcode;
    in_char_code    <= it.char_code;
    in_glyph_slot   <= it.glyph_slot;
    in_glyph_tex_x  <= it.tex_x;
    in_glyph_tex_y  <= it.tex_y;
    in_glyph_width  <= it.width;
    in_glyph_height <= it.height;
    in_glyph_drop   <= it.drop;
    do @(posedge clk); while (!in_ready);
    sb.take_item(it);
    if (it.opcode == OP_GLYPH) loaded[it.glyph_slot] = 1'b1;
    if (it.opcode != OP_RESERVED) items_sent++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_register(idx, value);
  endtask

  // Drop valid, let every quad drain, then give the engine time to go idle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_quads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(input int unsigned lh, input int unsigned lgap,
                           input int unsigned vgap, input int unsigned len,
                           input int unsigned base, input int unsigned cnt,
                           input int unsigned scl);
    write_reg(REG_LETTER_HEIGHT, lh);
    write_reg(REG_LETTER_SPACING, lgap);
    write_reg(REG_LINE_SPACING, vgap);
    write_reg(REG_LINE_LENGTH, len);
    write_reg(REG_CHAR_CODE_START, base);
    write_reg(REG_GLYPH_COUNT, cnt);
    write_reg(REG_GLYPH_SCALE, scl);
  endtask

  task automatic random_config();
    int unsigned r, base, cnt, scl;
    r    = $urandom_range(0, 99);
    base = (r < 15) ? 0 : (r < 25) ? 32'hFFFF : $urandom_range(0, 400);
    r    = $urandom_range(0, 99);
    cnt  = (r < 10) ? 0 : (r < 20) ? 1 : (r < 60) ? 256 : $urandom_range(1, 256);
    scl  = ($urandom_range(0, 1) == 0) ? $urandom_range(64, 1024) : pick_range(0, 65535);
    write_all(pick_range(0, 32767), pick_range(0, 32767), pick_range(0, 32767),
              pick_range(0, 255), base, cnt, scl);
  endtask

  task automatic send_string(input int unsigned len);
    send_item(noise_item(OP_BEGIN));
    repeat (len) send_item(char_item(pick_code()));
  endtask

  // Mostly well-formed strings, with table writes and noise mixed in
  task automatic run_mixture(input int unsigned count);
    int unsigned start, r;
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        send_item(noise_item(OP_GLYPH));
      else if (r < 11)
        send_item(noise_item(OP_RESERVED));
      else if (r < 13)
        send_item(noise_item(OP_BEGIN));
      else if (r < 15)
        send_item(char_item(pick_code()));
      else
        send_string(($urandom_range(0, 99) < 2) ? $urandom_range(260, 300)
                                                 : $urandom_range(1, 24));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: no glyph in range, so nothing is emitted
    send_item(char_item(16'd65));
    send_item(char_item(CHAR_SPACE));
    send_item(char_item(CHAR_NEWLINE));
    send_item(noise_item(OP_RESERVED));
    send_item(glyph_item(8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(glyph_item(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000));
    send_item(glyph_item(8'd1, 16'h1234, 16'hABCD, 16'hFFFF, 16'hFFFF, 16'h7FFF));
    send_item(glyph_item(8'd2, 16'h5A5A, 16'hA5A5, 16'd800, 16'd1200, -16'sd2000));
    drain();

    // Short lines: auto wrap, space in range, codes below and above range
    write_all(1638, 100, 200, 2, 32, 256, 256);
    send_item(noise_item(OP_BEGIN));
    send_item(char_item(16'd33));
    send_item(char_item(16'd34));
    send_item(char_item(CHAR_SPACE));
    send_item(char_item(16'd287));
    send_item(char_item(16'd31));
    send_item(char_item(CHAR_NEWLINE));
    send_item(char_item(16'hFFFF));
    drain();

    // Extremes: cursor saturates both ways, scale and drop saturate
    write_all(32767, 32767, 32767, 0, 32'hFFFE, 2, 65535);
    send_item(noise_item(OP_BEGIN));
    send_item(char_item(16'hFFFF));
    send_item(char_item(16'hFFFF));
    send_item(char_item(CHAR_SPACE));
    send_item(char_item(16'hFFFE));
    send_item(char_item(CHAR_NEWLINE));
    send_item(char_item(CHAR_NEWLINE));
    send_item(char_item(16'hFFFF));
    drain();

    // Load random table slots, stall the result side, then overflow the vertex limit
    write_all(1638, 50, 100, 40, 32, 256, 256);
    repeat (64) send_item(noise_item(OP_GLYPH));
    drain();
    hold_req     = 1'b1;
    steady_input = 1'b1;
    send_item(noise_item(OP_BEGIN));
    repeat (30) send_item(char_item(pick_glyph_code()));
    steady_input = 1'b0;
    send_item(noise_item(OP_BEGIN));
    repeat (290) send_item(char_item(pick_glyph_code()));
    run_mixture(100);
    drain();

    // Random settings and strings
    while (items_sent < ITEM_TARGET) begin
      random_config();
      steady_input = ($urandom_range(0, 3) == 0);
      run_mixture(150);
      drain();
    end

    if (sb.errors == 0 && sb.expected_quads.size() == 0) begin
      $display("glyph_layout_engine_unit_tb: PASS");
    end else begin
      $display("glyph_layout_engine_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
